// ===== hw/rtl/tournament_tree_merge_assert.svh =====
// Assertion macros for the checker of the winner-tree merge.
`ifndef TOURNAMENT_TREE_MERGE_ASSERT_SVH
`define TOURNAMENT_TREE_MERGE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TTM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("winner-tree merge check failed");

// The consequent must hold in the cycle after the antecedent.
`define TTM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("winner-tree merge check failed");

`endif

// ===== hw/rtl/ttm_pkg.sv =====
package ttm_pkg;

   // Fixed widths of the item fields.
   localparam int SRC_PORT_W  = 4;
   localparam int TIME_W      = 64;
   localparam int PAY_PORT_W  = 32;

endpackage

// ===== hw/rtl/tournament_tree_merge.sv =====
// An accepted item writes its leaf, then walks the path to the root one level a cycle
// through the single read port of the tree memory, over the depth of its leaf (4 for
// sixteen sources); the root is then loaded into the result register. An item with an
// unknown source goes straight to the result. No new item is taken until that is loaded.
// Reset clears the state machine, the result valid and every full bit, the root's too; the
// tree memory and held entries are not, as an entry only counts while its full bit is set.
module tournament_tree_merge #(
   parameter int NUM_SOURCES  = 16,
   parameter int PAYLOAD_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [ttm_pkg::SRC_PORT_W-1:0] req_source_index,
   input  logic [ttm_pkg::TIME_W-1:0]     req_event_time,
   input  logic [ttm_pkg::PAY_PORT_W-1:0] req_event_payload,
   input  logic                           req_end_of_source,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_winner_valid,
   output logic [ttm_pkg::SRC_PORT_W-1:0] rsp_winner_source,
   output logic [ttm_pkg::TIME_W-1:0]     rsp_winner_time,
   output logic [ttm_pkg::PAY_PORT_W-1:0] rsp_winner_payload
);

   localparam int SRC_W  = $clog2(NUM_SOURCES);
   localparam int POS_W  = SRC_W + 1;
   localparam int DEPTH  = 2 * NUM_SOURCES;
   localparam int DATA_W = (PAYLOAD_BITS < ttm_pkg::PAY_PORT_W) ? PAYLOAD_BITS
                                                                 : ttm_pkg::PAY_PORT_W;
   localparam int ENT_W  = SRC_W + ttm_pkg::TIME_W + DATA_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DONE
   } state_type;

   state_type                    state_ff, state_in;
   logic [POS_W-1:0]             pos_ff, pos_in;
   logic [ENT_W-1:0]             cur_ent_ff, cur_ent_in;
   logic                         cur_full_ff, cur_full_in;
   logic [ENT_W-1:0]             root_ent_ff, root_ent_in;
   logic                         root_full_ff, root_full_in;
   logic                         leaf_full_ff [NUM_SOURCES];
   logic                         leaf_full_in [NUM_SOURCES];
   logic                         node_full_ff [NUM_SOURCES-1];
   logic                         node_full_in [NUM_SOURCES-1];
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_winner_valid_ff, rsp_winner_valid_in;
   logic [SRC_W-1:0]             rsp_src_ff, rsp_src_in;
   logic [ttm_pkg::TIME_W-1:0]   rsp_time_ff, rsp_time_in;
   logic [DATA_W-1:0]            rsp_data_ff, rsp_data_in;

   logic                         mem_wr_en;
   logic [POS_W-1:0]             mem_wr_addr;
   logic [ENT_W-1:0]             mem_wr_data;
   logic                         mem_rd_en;
   logic [POS_W-1:0]             mem_rd_addr;
   logic [ENT_W-1:0]             mem_rd_data;

   logic                         accept;
   logic                         req_in_range;
   logic [SRC_W-1:0]             req_src;
   logic [POS_W-1:0]             req_pos;
   logic [ENT_W-1:0]             req_ent;

   logic [POS_W-1:0]             sib_pos;
   logic [POS_W-1:0]             par_pos;
   logic [POS_W-1:0]             sib_leaf_pos;
   logic [POS_W-1:0]             sib_node_pos;
   logic [POS_W-1:0]             par_node_pos;
   logic                         sib_is_leaf;
   logic                         sib_full;
   logic [ENT_W-1:0]             left_ent, right_ent;
   logic                         left_full, right_full;
   logic [SRC_W-1:0]             left_src, right_src;
   logic [ttm_pkg::TIME_W-1:0]   left_time, right_time;
   logic                         pick_left;
   logic                         win_full;
   logic [ENT_W-1:0]             win_ent;
   logic [ttm_pkg::PAY_PORT_W-1:0] rsp_payload_wide;

   // Tree entries by heap position: leaves at NUM_SOURCES and up, nodes from one.
   ttm_ram #(
      .WIDTH (ENT_W),
      .DEPTH (DEPTH)
   ) u_tree_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Decode of the incoming item.
   assign req_ready    = (state_ff == ST_IDLE);
   assign accept       = req_valid && req_ready;
   assign req_in_range = (32'(req_source_index) < NUM_SOURCES);
   assign req_src      = SRC_W'(req_source_index);
   assign req_pos      = POS_W'(NUM_SOURCES) + POS_W'(req_src);
   assign req_ent      = req_end_of_source ? ENT_W'(0)
                       : {req_src, req_event_time, DATA_W'(req_event_payload)};

   // Sibling lookup and the match at the current level of the walk.
   assign sib_pos      = pos_ff ^ POS_W'(1);
   assign par_pos      = pos_ff >> 1;
   assign sib_leaf_pos = sib_pos - POS_W'(NUM_SOURCES);
   assign sib_node_pos = sib_pos - POS_W'(1);
   assign par_node_pos = par_pos - POS_W'(1);
   assign sib_is_leaf  = (sib_pos >= POS_W'(NUM_SOURCES));
   assign sib_full     = sib_is_leaf ? leaf_full_ff[sib_leaf_pos[SRC_W-1:0]]
                                     : node_full_ff[sib_node_pos[SRC_W-1:0]];

   always_comb begin
      if (pos_ff[0] == 1'b0) begin
         left_ent   = cur_ent_ff;
         left_full  = cur_full_ff;
         right_ent  = mem_rd_data;
         right_full = sib_full;
      end else begin
         left_ent   = mem_rd_data;
         left_full  = sib_full;
         right_ent  = cur_ent_ff;
         right_full = cur_full_ff;
      end
   end

   assign left_src   = left_ent[ENT_W-1 -: SRC_W];
   assign right_src  = right_ent[ENT_W-1 -: SRC_W];
   assign left_time  = left_ent[DATA_W +: ttm_pkg::TIME_W];
   assign right_time = right_ent[DATA_W +: ttm_pkg::TIME_W];

   // Earlier time wins; on a tie the lower source wins; an empty side always loses.
   assign pick_left = left_full && (!right_full || (left_time < right_time)
                      || ((left_time == right_time) && (left_src <= right_src)));
   assign win_full  = left_full || right_full;
   assign win_ent   = pick_left ? left_ent : right_ent;

   // Sequencer: write the leaf, one level of the path each cycle, then the result.
   always_comb begin
      state_in            = state_ff;
      pos_in              = pos_ff;
      cur_ent_in          = cur_ent_ff;
      cur_full_in         = cur_full_ff;
      root_ent_in         = root_ent_ff;
      root_full_in        = root_full_ff;
      leaf_full_in        = leaf_full_ff;
      node_full_in        = node_full_ff;
      rsp_valid_in        = rsp_valid_ff && !rsp_ready;
      rsp_winner_valid_in = rsp_winner_valid_ff;
      rsp_src_in          = rsp_src_ff;
      rsp_time_in         = rsp_time_ff;
      rsp_data_in         = rsp_data_ff;
      mem_wr_en           = 1'b0;
      mem_wr_addr         = req_pos;
      mem_wr_data         = req_ent;
      mem_rd_en           = 1'b0;
      mem_rd_addr         = req_pos ^ POS_W'(1);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_in_range) begin
                  mem_wr_en             = 1'b1;
                  mem_rd_en             = 1'b1;
                  leaf_full_in[req_src] = !req_end_of_source;
                  cur_ent_in            = req_ent;
                  cur_full_in           = !req_end_of_source;
                  pos_in                = req_pos;
                  state_in              = ST_WALK;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_WALK: begin
            mem_wr_en                             = 1'b1;
            mem_wr_addr                           = par_pos;
            mem_wr_data                           = win_ent;
            node_full_in[par_node_pos[SRC_W-1:0]] = win_full;
            cur_ent_in                            = win_ent;
            cur_full_in                           = win_full;
            pos_in                                = par_pos;
            mem_rd_addr                           = par_pos ^ POS_W'(1);
            if (par_pos == POS_W'(1)) begin
               root_ent_in  = win_ent;
               root_full_in = win_full;
               state_in     = ST_DONE;
            end else begin
               mem_rd_en = 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in        = 1'b1;
               rsp_winner_valid_in = root_full_ff;
               rsp_src_in          = root_full_ff ? root_ent_ff[ENT_W-1 -: SRC_W]
                                                  : SRC_W'(0);
               rsp_time_in         = root_full_ff ? root_ent_ff[DATA_W +: ttm_pkg::TIME_W]
                                                  : ttm_pkg::TIME_W'(0);
               rsp_data_in         = root_full_ff ? root_ent_ff[DATA_W-1:0] : DATA_W'(0);
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, full bits and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         root_full_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cur_full_ff  <= 1'b0;
         for (int i = 0; i < NUM_SOURCES; i++) begin
            leaf_full_ff[i] <= 1'b0;
         end
         for (int i = 0; i < NUM_SOURCES - 1; i++) begin
            node_full_ff[i] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         root_full_ff <= root_full_in;
         rsp_valid_ff <= rsp_valid_in;
         cur_full_ff  <= cur_full_in;
         leaf_full_ff <= leaf_full_in;
         node_full_ff <= node_full_in;
      end
      pos_ff              <= pos_in;
      cur_ent_ff          <= cur_ent_in;
      root_ent_ff         <= root_ent_in;
      rsp_winner_valid_ff <= rsp_winner_valid_in;
      rsp_src_ff          <= rsp_src_in;
      rsp_time_ff         <= rsp_time_in;
      rsp_data_ff         <= rsp_data_in;
   end

   // Widen the kept payload bits back to the port.
   always_comb begin
      rsp_payload_wide              = '0;
      rsp_payload_wide[DATA_W-1:0]  = rsp_data_ff;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_winner_valid   = rsp_winner_valid_ff;
   assign rsp_winner_source  = ttm_pkg::SRC_PORT_W'(rsp_src_ff);
   assign rsp_winner_time    = rsp_time_ff;
   assign rsp_winner_payload = rsp_payload_wide;

endmodule

// ===== hw/rtl/ttm_ram.sv =====
module ttm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/ttm_checker.sv =====
`include "tournament_tree_merge_assert.svh"

module ttm_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic                           rsp_winner_valid,
   input  logic [ttm_pkg::SRC_PORT_W-1:0] rsp_winner_source,
   input  logic [ttm_pkg::TIME_W-1:0]     rsp_winner_time,
   input  logic [ttm_pkg::PAY_PORT_W-1:0] rsp_winner_payload
);

   logic rsp_stall;
   logic rsp_empty_tree;
   logic rsp_fields_zero;

   assign rsp_stall       = rsp_valid && !rsp_ready;
   assign rsp_empty_tree  = rsp_valid && !rsp_winner_valid;
   assign rsp_fields_zero = (rsp_winner_source == '0) && (rsp_winner_time == '0)
                            && (rsp_winner_payload == '0);

   // A stalled result stays offered, with its time and source unchanged.
   `TTM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid)
   `TTM_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_stall, $stable(rsp_winner_time) && $stable(rsp_winner_source))

   // With every source exhausted the result fields read as zero.
   `TTM_ASSERT_SAME(a_empty_zero, clock, reset, rsp_empty_tree, rsp_fields_zero)

   // The block works on one item at a time: no second item right after an accept.
   `TTM_ASSERT_NEXT(a_one_item, clock, reset, req_valid && req_ready, !req_ready)

endmodule

bind tournament_tree_merge ttm_checker u_ttm_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_winner_valid   (rsp_winner_valid),
   .rsp_winner_source  (rsp_winner_source),
   .rsp_winner_time    (rsp_winner_time),
   .rsp_winner_payload (rsp_winner_payload)
);

// ===== tb/tournament_tree_merge_tb.sv =====
`timescale 1ns / 100ps

module tournament_tree_merge_tb;

   localparam int NUM_SRC        = 16;
   localparam int SW             = ttm_pkg::SRC_PORT_W;
   localparam int TW             = ttm_pkg::TIME_W;
   localparam int PW             = ttm_pkg::PAY_PORT_W;
   localparam int RANDOM_ITEMS   = 480;
   localparam int CALM_TAIL      = 60;
   localparam int LONG_HOLD_AT   = 150;
   localparam int LONG_HOLD_LEN  = 200;
   localparam int SETTLE_CYCLES  = 12;
   localparam int WATCHDOG_LIMIT = 1000;

   // Time-stamp regimes for an episode of merged streams.
   localparam int STAMP_TIES = 0;
   localparam int STAMP_WIDE = 1;
   localparam int STAMP_TOP  = 2;
   localparam int STAMP_LOW  = 3;

   typedef struct packed {
      logic [SW-1:0] source;
      logic [TW-1:0] stamp;
      logic [PW-1:0] payload;
      logic          last;
   } event_item_type;

   typedef struct packed {
      logic           drain_first;
      event_item_type ev;
   } queued_event_type;

   typedef struct packed {
      logic          present;
      logic [SW-1:0] source;
      logic [TW-1:0] stamp;
      logic [PW-1:0] payload;
   } winner_type;

   typedef struct packed {
      logic [NUM_SRC-1:0]         full;
      logic [NUM_SRC-1:0][TW-1:0] stamp;
      logic [NUM_SRC-1:0][PW-1:0] payload;
   } merge_state_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   logic [SW-1:0] req_source_index = '0;
   logic [TW-1:0] req_event_time = '0;
   logic [PW-1:0] req_event_payload = '0;
   logic          req_end_of_source = 1'b0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic          rsp_winner_valid;
   logic [SW-1:0] rsp_winner_source;
   logic [TW-1:0] rsp_winner_time;
   logic [PW-1:0] rsp_winner_payload;

   queued_event_type items_pending[$];
   winner_type       winners_due[$];
   merge_state_type  plan_state = '0;
   merge_state_type  leaf_shadow = '0;
   queued_event_type next_item;
   winner_type       want;
   winner_type       got;

   int   items_made = 0;
   int   items_taken = 0;
   int   winners_seen = 0;
   int   mismatches = 0;
   int   empty_results = 0;
   int   source_ends = 0;
   int   replacements = 0;
   int   send_gap = 0;
   int   hold_left = 0;
   int   idle_cycles = 0;
   logic req_fire = 1'b0;
   logic long_hold_done = 1'b0;

   tournament_tree_merge #(
      .NUM_SOURCES  (NUM_SRC),
      .PAYLOAD_BITS (PW)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_source_index   (req_source_index),
      .req_event_time     (req_event_time),
      .req_event_payload  (req_event_payload),
      .req_end_of_source  (req_end_of_source),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_winner_valid   (rsp_winner_valid),
      .rsp_winner_source  (rsp_winner_source),
      .rsp_winner_time    (rsp_winner_time),
      .rsp_winner_payload (rsp_winner_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Load an event into its source's leaf, or empty the leaf when the source ends.
   function automatic merge_state_type load_leaf(merge_state_type s, event_item_type e);
      if (e.source < NUM_SRC) begin
         s.full[e.source]    = !e.last;
         s.stamp[e.source]   = e.last ? '0 : e.stamp;
         s.payload[e.source] = e.last ? '0 : e.payload;
      end
      return s;
   endfunction

   // The earliest event over all full leaves; on equal times the lower source is kept,
   // since the scan runs upwards and only a strictly earlier time displaces the leader.
   function automatic winner_type earliest_event(merge_state_type s);
      winner_type w;
      w = '0;
      for (int i = 0; i < NUM_SRC; i++) begin
         if (s.full[i] && (!w.present || s.stamp[i] < w.stamp)) begin
            w.present = 1'b1;
            w.source  = SW'(i);
            w.stamp   = s.stamp[i];
            w.payload = s.payload[i];
         end
      end
      return w;
   endfunction

   function automatic logic [TW-1:0] random_stamp(int regime);
      case (regime)
         STAMP_TIES: return TW'($urandom_range(0, 7));
         STAMP_TOP:  return '1 - TW'($urandom_range(0, 255));
         STAMP_LOW:  return TW'($urandom_range(0, 100000));
         default:    return {$urandom, $urandom};
      endcase
   endfunction

   // Queue one item and keep the planning copy of the leaves up to date.
   task automatic add_item(input logic [SW-1:0] src, input logic [TW-1:0] stamp,
                           input logic [PW-1:0] payload, input logic last,
                           input logic drain_first);
      queued_event_type q;
      q.drain_first = drain_first;
      q.ev          = '{source: src, stamp: stamp, payload: payload, last: last};
      items_pending.insert(items_pending.size(), q);
      plan_state = load_leaf(plan_state, q.ev);
      items_made++;
   endtask

   // Episodes of merged streams: prime some sources, then keep refilling the source that
   // currently leads, as a consumer would, with some noise and some streams left open.
   task automatic add_merge_episodes(input int count);
      int            regime;
      int            primed;
      int            steps;
      int            stop_at;
      logic          first;
      logic [TW-1:0] following;
      winner_type    lead;
      first   = 1'b1;
      stop_at = items_made + count;
      while (items_made < stop_at) begin
         regime = $urandom_range(STAMP_TIES, STAMP_LOW);
         primed = $urandom_range(1, NUM_SRC);
         for (int i = 0; i < primed; i++) begin
            add_item(SW'($urandom_range(0, NUM_SRC - 1)), random_stamp(regime), $urandom,
                     1'b0, (i == 0) && (first || $urandom_range(0, 4) == 0));
         end
         first = 1'b0;
         steps = $urandom_range(10, 60);
         for (int j = 0; j < steps; j++) begin
            lead = earliest_event(plan_state);
            if ($urandom_range(0, 9) == 0) begin
               add_item(SW'($urandom_range(0, NUM_SRC - 1)),
                        random_stamp($urandom_range(STAMP_TIES, STAMP_LOW)), $urandom,
                        $urandom_range(0, 3) == 0, 1'b0);
            end else if (!lead.present) begin
               break;
            end else if ($urandom_range(0, 7) == 0) begin
               add_item(lead.source, {$urandom, $urandom}, $urandom, 1'b1, 1'b0);
            end else begin
               case (regime)
                  STAMP_TIES: following = lead.stamp + TW'($urandom_range(0, 2));
                  STAMP_WIDE: following = lead.stamp + TW'($urandom);
                  default:    following = lead.stamp +
                                 ($urandom_range(0, 3) == 0 ? '0 : TW'($urandom_range(1, 1000)));
               endcase
               // A stream that would wrap past the top of the time range ends instead.
               add_item(lead.source, following, $urandom, following < lead.stamp, 1'b0);
            end
         end
         // Most episodes close every stream that is still open.
         if ($urandom_range(0, 3) != 0) begin
            for (int i = 0; i < NUM_SRC; i++) begin
               if (plan_state.full[i]) begin
                  add_item(SW'(i), {$urandom, $urandom}, $urandom, 1'b1, 1'b0);
               end
            end
         end
      end
   endtask

   // Sender: offer the next queued item, with random gaps outside the calm tail.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (send_gap > 0) begin
            send_gap  <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (items_pending.size() == 0 ||
                      (items_pending[0].drain_first && winners_due.size() != 0)) begin
            req_valid <= 1'b0;
         end else if (items_taken < items_made - CALM_TAIL && $urandom_range(0, 5) == 0) begin
            send_gap  <= $urandom_range(1, 12) - 1;
            req_valid <= 1'b0;
         end else begin
            next_item = items_pending.pop_front();
            req_source_index  <= next_item.ev.source;
            req_event_time    <= next_item.ev.stamp;
            req_event_payload <= next_item.ev.payload;
            req_end_of_source <= next_item.ev.last;
            req_valid         <= 1'b1;
         end
      end
   end

   // Receiver: short random stalls, and once a long hold so that the block backs up.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (!long_hold_done && items_taken >= LONG_HOLD_AT) begin
         long_hold_done <= 1'b1;
         hold_left      <= LONG_HOLD_LEN - 1;
         rsp_ready      <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (items_taken < items_made - CALM_TAIL && $urandom_range(0, 7) == 0) begin
         hold_left <= $urandom_range(1, 12) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Check each winner leaving the block, then predict the winner for each item taken in.
   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            winners_seen++;
            got = '{present: rsp_winner_valid, source: rsp_winner_source,
                    stamp: rsp_winner_time, payload: rsp_winner_payload};
            if (winners_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("Unexpected winner: valid=%0b source=%0d time=%h payload=%h",
                           got.present, got.source, got.stamp, got.payload);
               end
            end else begin
               want = winners_due.pop_front();
               if (got.present !== want.present || got.source !== want.source ||
                   got.stamp !== want.stamp || got.payload !== want.payload) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("Winner %0d wrong: expected valid=%0b source=%0d time=%h payload=%h",
                              winners_seen, want.present, want.source, want.stamp, want.payload);
                     $display("   got valid=%0b source=%0d time=%h payload=%h",
                              got.present, got.source, got.stamp, got.payload);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            items_taken++;
            if (req_end_of_source) begin
               source_ends++;
            end else if (leaf_shadow.full[req_source_index]) begin
               replacements++;
            end
            leaf_shadow = load_leaf(leaf_shadow, event_item_type'({req_source_index,
                             req_event_time, req_event_payload, req_end_of_source}));
            want = earliest_event(leaf_shadow);
            if (!want.present) begin
               empty_results++;
            end
            winners_due.insert(winners_due.size(), want);
         end
      end
   end

   // Watchdog: ends the run when no item has moved on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no item moved for %0d cycles", idle_cycles);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      // Directed items: extremes of time and payload, ties, replacement and ending sources.
      add_item(4'd0, '1, '1, 1'b1, 1'b0);                      // nothing held: empty winner
      add_item(4'd15, '1, '1, 1'b0, 1'b0);                     // latest time, full payload
      add_item(4'd0, '1, 32'h5555_5555, 1'b0, 1'b0);           // equal times: lower source
      add_item(4'd7, '0, '0, 1'b0, 1'b0);                      // earliest time
      add_item(4'd3, '0, 32'hAAAA_AAAA, 1'b0, 1'b0);           // tie at zero
      add_item(4'd3, 64'h5555_5555_5555_5555, 32'h1, 1'b0, 1'b0); // full leaf replaced
      add_item(4'd7, 64'hAAAA_AAAA_AAAA_AAAA, '1, 1'b1, 1'b0); // end with junk fields
      add_item(4'd8, 64'hAAAA_AAAA_AAAA_AAAA, 32'hFFFF_0000, 1'b0, 1'b0);
      add_item(4'd3, '0, '0, 1'b1, 1'b0);
      add_item(4'd8, '1, '1, 1'b1, 1'b0);
      add_item(4'd0, 64'h5555_5555_5555_5555, 32'h0000_FFFF, 1'b1, 1'b0);
      add_item(4'd15, '0, '0, 1'b1, 1'b0);                     // last source ends
      add_item(4'd15, '1, '1, 1'b1, 1'b0);                     // end on an empty leaf
      // Each new event is earlier than all before it, on leaves spread across the tree.
      for (int i = 0; i < 8; i++) begin
         add_item(SW'(2 * i + 1), TW'(8 - i), 32'h1234_0000 + PW'(i), 1'b0, 1'b0);
      end
      add_merge_episodes(RANDOM_ITEMS);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (items_pending.size() != 0 || req_valid) @(posedge clock);
      while (winners_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Merged %0d items (%0d stream ends, %0d leaf replacements) into %0d winners,",
               items_taken, source_ends, replacements, winners_seen);
      $display("%0d of them with every source empty; %0d mismatches.",
               empty_results, mismatches);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/ttm_pkg.sv
hw/rtl/ttm_ram.sv
hw/rtl/tournament_tree_merge.sv
hw/rtl/ttm_checker.sv
tb/tournament_tree_merge_tb.sv
